FILE: hw/rtl/lodd_pkg.sv
// shared types and constants of the lock-order deadlock detector
package lodd_pkg;

  localparam int DEF_THREADS = 8;
  localparam int DEF_MUTEXES = 16;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;

  typedef enum logic [1:0] {
    OP_ACQ,
    OP_REL,
    OP_CHK,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] mode;
    logic [2:0] tid;
    logic [3:0] mid;
  } lodd_item_t;

endpackage

FILE: hw/rtl/lodd_front.sv
// request intake: classification and a short queue toward the execution unit
module lodd_front #(
  parameter int THREADS = 8,
  parameter int MUTEXES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [2:0]          in_thread_id,
  input  logic [3:0]          in_mutex_id,
  output logic                q_valid,
  output lodd_pkg::lodd_item_t q_item,
  input  logic                q_pop
);
  import lodd_pkg::*;

  localparam logic [Q_AW:0] Q_FULL = (Q_AW + 1)'(Q_DEPTH);

  lodd_item_t      q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  lodd_item_t      cls;
  logic            in_range;
  logic            push;
  logic            pop;

  assign in_range = (int'(in_thread_id) < THREADS) && (int'(in_mutex_id) < MUTEXES);

  always_comb begin
    cls.mode = in_mode;
    cls.tid  = in_thread_id;
    cls.mid  = in_mutex_id;
    case (in_mode)
      MODE_ACQUIRE: cls.op = in_range ? OP_ACQ : OP_NOP;
      MODE_RELEASE: cls.op = in_range ? OP_REL : OP_NOP;
      MODE_CHECK:   cls.op = OP_CHK;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign busy    = (count_r == Q_FULL);
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_FULL)
    else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/lodd_back.sv
// execution unit: held-lock memory, edge matrix and closure iteration
module lodd_back #(
  parameter int THREADS = 8,
  parameter int MUTEXES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lodd_pkg::lodd_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  output logic                out_cycle_found,
  output logic [1:0]          out_done_mode
);
  import lodd_pkg::*;

  localparam int TAW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int KW  = $clog2(MUTEXES);
  localparam logic [KW-1:0] KLAST = KW'(MUTEXES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WB,
    S_ITER,
    S_FIN
  } state_t;

  state_t             state_r;
  lodd_item_t         cur_r;
  logic [KW-1:0]      k_r;
  logic [MUTEXES-1:0] edges_r [MUTEXES];
  logic [MUTEXES-1:0] reach_r [MUTEXES];
  logic [MUTEXES-1:0] held_mem [THREADS];
  logic [THREADS-1:0] held_vld_r;
  logic [MUTEXES-1:0] held_rd_r;
  logic               held_rd_vld_r;
  logic               out_valid_r;
  logic               out_cycle_r;
  logic [1:0]         out_mode_r;

  logic [MUTEXES-1:0] held_q;
  logic [MUTEXES-1:0] mbit;
  logic [MUTEXES-1:0] held_wdata;
  logic [MUTEXES-1:0] diag;
  logic [TAW-1:0]     rd_addr;
  logic [TAW-1:0]     wr_addr;
  logic               held_wr;

  assign q_pop   = q_valid && (state_r == S_IDLE);
  assign rd_addr = TAW'(q_item.tid);
  assign wr_addr = TAW'(cur_r.tid);
  assign held_q  = held_rd_vld_r ? held_rd_r : '0;
  assign held_wr = (state_r == S_WB) && ((cur_r.op == OP_ACQ) || (cur_r.op == OP_REL));

  always_comb begin
    for (int j = 0; j < MUTEXES; j++) begin
      mbit[j] = (int'(cur_r.mid) == j);
      diag[j] = reach_r[j][j];
    end
  end

  assign held_wdata = (cur_r.op == OP_ACQ) ? (held_q | mbit) : (held_q & ~mbit);

  always_ff @(posedge clk) begin
    held_rd_r <= held_mem[rd_addr];
    if (held_wr) begin
      held_mem[wr_addr] <= held_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      held_vld_r    <= '0;
      held_rd_vld_r <= 1'b0;
      out_valid_r   <= 1'b0;
      k_r           <= '0;
      for (int i = 0; i < MUTEXES; i++) begin
        edges_r[i] <= '0;
      end
    end else begin
      out_valid_r   <= 1'b0;
      held_rd_vld_r <= held_vld_r[rd_addr];
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            case (q_item.op)
              OP_ACQ, OP_REL: state_r <= S_WB;
              OP_CHK: begin
                for (int i = 0; i < MUTEXES; i++) begin
                  reach_r[i] <= edges_r[i];
                end
                k_r     <= '0;
                state_r <= S_ITER;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_cycle_r <= 1'b0;
                out_mode_r  <= q_item.mode;
              end
            endcase
          end
        end
        S_WB: begin
          if (cur_r.op == OP_ACQ) begin
            for (int i = 0; i < MUTEXES; i++) begin
              if (held_q[i]) begin
                edges_r[i] <= edges_r[i] | mbit;
              end
            end
          end
          held_vld_r[wr_addr] <= 1'b1;
          out_valid_r <= 1'b1;
          out_cycle_r <= 1'b0;
          out_mode_r  <= cur_r.mode;
          state_r     <= S_IDLE;
        end
        S_ITER: begin
          for (int i = 0; i < MUTEXES; i++) begin
            if (reach_r[i][k_r]) begin
              reach_r[i] <= reach_r[i] | reach_r[k_r];
            end
          end
          if (k_r == KLAST) begin
            state_r <= S_FIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_cycle_r <= |diag;
          out_mode_r  <= cur_r.mode;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_cycle_r;
  assign out_done_mode   = out_mode_r;

  a_iter_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER && k_r == KLAST) |=> state_r == S_FIN)
    else $error("closure did not finish after last pivot");

  a_cycle_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cycle_r) |-> out_mode_r == MODE_CHECK)
    else $error("cycle flag on a non-check result");

  a_wb_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> (state_r == S_IDLE && out_valid_r))
    else $error("write-back did not complete with a result");

endmodule

FILE: hw/rtl/lock_order_deadlock_detector_top.sv
// top level of the lock-order deadlock detector
// A request is taken when start is high and busy is low; busy rises only when the
// two-entry request queue is full. Every request gives one result, shown for one
// cycle with out_valid; the receiver cannot stall it. Acquire and release pass a
// held-set read, then write-back and edge update in the execution unit. A check
// loads the edge matrix, runs one closure step per pivot mutex, then tests the
// diagonal. Mode 3 and out-of-range acquire or release answer straight from idle.
module lock_order_deadlock_detector_top #(
  parameter int THREADS = lodd_pkg::DEF_THREADS,
  parameter int MUTEXES = lodd_pkg::DEF_MUTEXES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [2:0] in_thread_id,
  input  logic [3:0] in_mutex_id,
  output logic       out_valid,
  output logic       out_cycle_found,
  output logic [1:0] out_done_mode
);
  import lodd_pkg::*;

  logic       q_valid;
  logic       q_pop;
  lodd_item_t q_item;

  lodd_front #(
    .THREADS(THREADS),
    .MUTEXES(MUTEXES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_thread_id(in_thread_id),
    .in_mutex_id (in_mutex_id),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lodd_back #(
    .THREADS(THREADS),
    .MUTEXES(MUTEXES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_cycle_found(out_cycle_found),
    .out_done_mode  (out_done_mode)
  );

endmodule
